// ===== design/oaids_pkg.sv =====
// shared types and constants for the ordered array insert/delete/search core
package oaids_pkg;

    localparam int CAPACITY_DEF   = 128;
    localparam int VALUE_BITS_DEF = 32;
    localparam int OPCODE_BITS    = 3;
    localparam int POS_BITS       = 7;
    localparam int STATUS_BITS    = 2;
    localparam int SIZE_BITS      = 8;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DEL_LAST = 3'd2,
        OP_DEL_AT   = 3'd3,
        OP_SEARCH   = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch_req;
        logic set_status;
        logic idx_load_count;
        logic idx_load_pos;
        logic idx_load_zero;
        logic idx_inc;
        logic idx_dec;
        logic rd_up;
        logic rd_dn;
        logic rd_at;
        logic wr_shift;
        logic wr_val;
        logic count_inc;
        logic count_dec;
        logic set_found;
        logic load_out;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [OPCODE_BITS-1:0] op;
        logic                   ok;
        logic                   cnt_empty;
        logic                   pos_at_end;
        logic                   pos_last;
        logic                   up_last;
        logic                   dn_last;
        logic                   cnt_last;
        logic                   match;
        logic                   out_free;
    } sts_t;

endpackage

// ===== design/ordered_array_insert_delete_search_core.sv =====
// append writes at the end; insert first shifts the entries from position upward by one;
// delete-last only lowers the count; delete-at shifts the entries above position down;
// search scans from entry 0 to a match or the end; errors, unused opcodes finish at once
// each moved or compared entry gets a registered memory read, then a write or compare
// one item in flight; the next item is accepted the cycle after the result is loaded
// reset clears the fill count and output valid; entry contents are not cleared
module ordered_array_insert_delete_search_core #(
    parameter int CAPACITY   = oaids_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = oaids_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [oaids_pkg::OPCODE_BITS-1:0] opcode,
    input  logic [oaids_pkg::POS_BITS-1:0]    position,
    input  logic signed [VALUE_BITS-1:0]      value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [oaids_pkg::STATUS_BITS-1:0] status,
    output logic                              found,
    output logic [oaids_pkg::POS_BITS-1:0]    found_index,
    output logic [oaids_pkg::SIZE_BITS-1:0]   size_now
);

    import oaids_pkg::*;

    cmd_t cmd;
    sts_t sts;

    oaids_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    oaids_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (opcode),
        .position    (position),
        .value       (value),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .size_now    (size_now)
    );

endmodule

// ===== design/oaids_ram.sv =====
// generic single write port, single read port ram with registered read data
module oaids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/oaids_ctrl.sv =====
// controller state machine sequencing checks, shifts and the search scan
module oaids_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  oaids_pkg::sts_t sts,
    output oaids_pkg::cmd_t cmd
);

    import oaids_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_UP,
        S_WR_UP,
        S_RD_DN,
        S_WR_DN,
        S_RD_AT,
        S_CMP,
        S_PUT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.set_status = 1'b1;
                if (!sts.ok)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    unique case (sts.op)
                        OP_APPEND:
                        begin
                            cmd.idx_load_count = 1'b1;
                            state_next         = S_PUT;
                        end
                        OP_INSERT:
                        begin
                            cmd.idx_load_count = 1'b1;
                            state_next         = sts.pos_at_end ? S_PUT : S_RD_UP;
                        end
                        OP_DEL_LAST:
                        begin
                            cmd.count_dec = 1'b1;
                            state_next    = S_FINISH;
                        end
                        OP_DEL_AT:
                        begin
                            cmd.idx_load_pos = 1'b1;
                            if (sts.pos_last)
                            begin
                                cmd.count_dec = 1'b1;
                                state_next    = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_RD_DN;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (sts.cnt_empty)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                cmd.idx_load_zero = 1'b1;
                                state_next        = S_RD_AT;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_RD_UP:
            begin
                cmd.rd_up  = 1'b1;
                state_next = S_WR_UP;
            end
            S_WR_UP:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_dec  = 1'b1;
                state_next   = sts.up_last ? S_PUT : S_RD_UP;
            end
            S_RD_DN:
            begin
                cmd.rd_dn  = 1'b1;
                state_next = S_WR_DN;
            end
            S_WR_DN:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (sts.dn_last)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_RD_DN;
                end
            end
            S_RD_AT:
            begin
                cmd.rd_at  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (sts.match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_FINISH;
                end
                else if (sts.cnt_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD_AT;
                end
            end
            S_PUT:
            begin
                cmd.wr_val    = 1'b1;
                cmd.count_inc = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register is only loaded when the output side can take it
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded while output still held");

    // one memory write source at a time
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_shift && cmd.wr_val))
        else $error("shift write and value write together");

    // an accepted item is checked in the very next cycle
    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_req |=> (state_reg == S_DECIDE))
        else $error("accepted item not checked next cycle");

endmodule

// ===== design/oaids_dp.sv =====
// datapath: request registers, fill count, index counter, entry memory, result registers
module oaids_dp #(
    parameter int CAPACITY   = oaids_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = oaids_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [oaids_pkg::OPCODE_BITS-1:0]   opcode,
    input  logic [oaids_pkg::POS_BITS-1:0]      position,
    input  logic signed [VALUE_BITS-1:0]        value,
    input  oaids_pkg::cmd_t                     cmd,
    output oaids_pkg::sts_t                     sts,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [oaids_pkg::STATUS_BITS-1:0]   status,
    output logic                                found,
    output logic [oaids_pkg::POS_BITS-1:0]      found_index,
    output logic [oaids_pkg::SIZE_BITS-1:0]     size_now
);

    import oaids_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;

    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [OPCODE_BITS-1:0] req_op_reg;
    logic [POS_BITS-1:0]   req_pos_reg;
    logic [VALUE_BITS-1:0] req_val_reg;
    status_t               res_status_reg;
    logic                  res_found_reg;
    logic [IDX_W-1:0]      res_idx_reg;
    logic                  out_valid_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic                  out_found_reg;
    logic [POS_BITS-1:0]   out_index_reg;
    logic [SIZE_BITS-1:0]  out_size_reg;

    logic [CMP_W-1:0]      pos_x;
    logic [CMP_W-1:0]      cnt_x;
    logic [CMP_W-1:0]      idx_x;
    logic [CMP_W-1:0]      res_idx_x;
    logic                  full;
    logic                  empty;
    status_t               status_code;

    logic                  mem_wr_en;
    logic [VALUE_BITS-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    logic [VALUE_BITS-1:0] mem_rd_data;

    assign pos_x     = CMP_W'(req_pos_reg);
    assign cnt_x     = CMP_W'(count_reg);
    assign idx_x     = CMP_W'(idx_reg);
    assign res_idx_x = CMP_W'(res_idx_reg);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        status_code = ST_DONE;
        unique case (req_op_reg)
            OP_APPEND:
            begin
                if (full)
                begin
                    status_code = ST_FULL;
                end
            end
            OP_INSERT:
            begin
                priority if (full)
                begin
                    status_code = ST_FULL;
                end
                else if (pos_x > cnt_x)
                begin
                    status_code = ST_RANGE;
                end
            end
            OP_DEL_LAST:
            begin
                if (empty)
                begin
                    status_code = ST_EMPTY;
                end
            end
            OP_DEL_AT:
            begin
                priority if (empty)
                begin
                    status_code = ST_EMPTY;
                end
                else if (pos_x >= cnt_x)
                begin
                    status_code = ST_RANGE;
                end
            end
            default:
            begin
                status_code = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        sts.op         = req_op_reg;
        sts.ok         = (status_code == ST_DONE);
        sts.cnt_empty  = empty;
        sts.pos_at_end = (pos_x == cnt_x);
        sts.pos_last   = ((pos_x + CMP_W'(1)) == cnt_x);
        sts.up_last    = (idx_x == (pos_x + CMP_W'(1)));
        sts.dn_last    = ((idx_x + CMP_W'(2)) == cnt_x);
        sts.cnt_last   = ((idx_x + CMP_W'(1)) == cnt_x);
        sts.match      = (mem_rd_data == req_val_reg);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // memory ports: writes always land at the index counter
    assign mem_wr_en   = cmd.wr_shift | cmd.wr_val;
    assign mem_wr_data = cmd.wr_val ? req_val_reg : mem_rd_data;
    assign mem_rd_en   = cmd.rd_up | cmd.rd_dn | cmd.rd_at;

    always_comb
    begin
        priority if (cmd.rd_up)
        begin
            mem_rd_addr = idx_reg - IDX_W'(1);
        end
        else if (cmd.rd_dn)
        begin
            mem_rd_addr = idx_reg + IDX_W'(1);
        end
        else
        begin
            mem_rd_addr = idx_reg;
        end
    end

    oaids_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (idx_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_op_reg    <= opcode;
            req_pos_reg   <= position;
            req_val_reg   <= value;
            res_found_reg <= 1'b0;
            res_idx_reg   <= '0;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= status_code;
        end
        if (cmd.set_found)
        begin
            res_found_reg <= 1'b1;
            res_idx_reg   <= idx_reg;
        end
        priority if (cmd.idx_load_count)
        begin
            idx_reg <= count_reg[IDX_W-1:0];
        end
        else if (cmd.idx_load_pos)
        begin
            idx_reg <= pos_x[IDX_W-1:0];
        end
        else if (cmd.idx_load_zero)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_index_reg  <= res_idx_x[POS_BITS-1:0];
            out_size_reg   <= cnt_x[SIZE_BITS-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign found_index = out_index_reg;
    assign size_now    = out_size_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_x <= CMP_W'(CAPACITY))
        else $error("fill count above capacity");

    // shifted entries stay inside the filled region or the slot an insert opens
    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_shift |-> (idx_x <= cnt_x))
        else $error("shift write outside filled entries");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |=> (count_reg == ($past(count_reg) + CNT_W'(1))))
        else $error("fill count did not advance by one");

endmodule
